@@ rtl/tcw_pkg.sv @@
// Shared types and constants for the text console writer.
package tcw_pkg;

	// Character codes with a fixed meaning.
	localparam logic [7:0] BLANK_CODE   = 8'h20;
	localparam logic [7:0] NEWLINE_CODE = 8'h0A;

	// Console commands.
	typedef enum logic [1:0] {
		CMD_PUT    = 2'd0,
		CMD_DELETE = 2'd1,
		CMD_READ   = 2'd2,
		CMD_PLACE  = 2'd3
	} cmd_t;

	// One request beat.
	typedef struct packed {
		cmd_t       command;
		logic [7:0] char_code;
		logic [6:0] column;
		logic [4:0] row;
	} req_t;

	// One response beat.
	typedef struct packed {
		logic [6:0]  cursor_column;
		logic [4:0]  cursor_row;
		logic [10:0] cursor_location;
		logic [7:0]  read_char;
		logic        scrolled;
	} rsp_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_SCROLL
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic commit;
		logic rd_en;
		logic load_rd;
		logic clr_we;
	} ctrl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_read;
		logic scroll;
		logic out_free;
		logic clr_done;
	} status_t;

endpackage

@@ rtl/tcw_ctrl.sv @@
// Controller state machine of the text console writer.
module tcw_ctrl import tcw_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	output logic    req_stall,
	input  status_t status,
	output ctrl_t   ctrl
);

	state_t state_q;
	state_t state_nxt;

	// State register; reset starts the screen clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (status.clr_done) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (req_valid) state_nxt = ST_EXEC;
			end
			ST_EXEC: begin
				if (status.is_read) begin
					state_nxt = ST_READ;
				end else if (status.out_free) begin
					state_nxt = status.scroll ? ST_SCROLL : ST_IDLE;
				end
			end
			ST_READ: begin
				if (status.out_free) state_nxt = ST_IDLE;
			end
			ST_SCROLL: begin
				if (status.clr_done) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_CLEAR;
		endcase
	end

	// Command outputs.
	always_comb begin
		ctrl         = '0;
		req_stall    = 1'b1;
		case (state_q)
			ST_CLEAR: begin
				ctrl.clr_we = 1'b1;
			end
			ST_IDLE: begin
				req_stall   = 1'b0;
				ctrl.accept = req_valid;
			end
			ST_EXEC: begin
				ctrl.rd_en  = status.is_read;
				ctrl.commit = !status.is_read && status.out_free;
			end
			ST_READ: begin
				ctrl.load_rd = status.out_free;
			end
			ST_SCROLL: begin
				ctrl.clr_we = 1'b1;
			end
			default: begin
				ctrl = '0;
			end
		endcase
	end

endmodule

@@ rtl/tcw_dpath.sv @@
// Datapath of the text console writer: cursor, screen memory and response register.
module tcw_dpath import tcw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic    clk,
	input  logic    arst_n,
	input  req_t    req,
	input  ctrl_t   ctrl,
	output status_t status,
	output logic    rsp_valid,
	input  logic    rsp_stall,
	output rsp_t    rsp
);

	localparam int CELLS  = COLUMNS * ROWS;
	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int ADDR_W = $clog2(CELLS);

	localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);
	localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
	localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(CELLS - 1);
	localparam logic [ADDR_W-1:0] ROW_SPAN  = ADDR_W'(COLUMNS - 1);

	// Linear cell index of a row and column.
	function automatic logic [ADDR_W-1:0] lin(input logic [ROW_W-1:0] r,
		input logic [COL_W-1:0] c);
		lin = ADDR_W'(r) * ADDR_W'(COLUMNS) + ADDR_W'(c);
	endfunction

	// Screen store; rows rotate through it by the top row pointer.
	logic [7:0] cells [CELLS];

	logic [COL_W-1:0]  cur_col_q;
	logic [ROW_W-1:0]  cur_row_q;
	logic [ROW_W-1:0]  top_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic [ADDR_W-1:0] clr_end_q;
	cmd_t              cmd_s1;
	logic [7:0]        code_s1;
	logic [COL_W-1:0]  col_s1;
	logic [ROW_W-1:0]  row_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [7:0]        rdata_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic [COL_W-1:0]  req_col;
	logic [ROW_W-1:0]  req_row;
	logic [COL_W-1:0]  del_col;
	logic [ROW_W-1:0]  del_row;
	logic [COL_W-1:0]  lcol;
	logic [ROW_W-1:0]  lrow;
	logic [ROW_W:0]    psum;
	logic [ROW_W-1:0]  phys_row;
	logic              wrap;
	logic              scroll;
	logic [COL_W-1:0]  nxt_col;
	logic [ROW_W-1:0]  nxt_row;
	logic [ADDR_W-1:0] nxt_loc;
	logic [ADDR_W-1:0] top_base;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [7:0]        mem_wdata;

	// Requested position, saturated to the screen.
	always_comb begin
		req_col = (8'(req.column) >= 8'(COLUMNS)) ? COL_LAST : COL_W'(req.column);
		req_row = (7'(req.row) >= 7'(ROWS)) ? ROW_LAST : ROW_W'(req.row);
	end

	// Cursor after a delete: back one cell, to the previous row's end, or stay home.
	always_comb begin
		if (cur_col_q == '0) begin
			if (cur_row_q != '0) begin
				del_col = COL_LAST;
				del_row = cur_row_q - ROW_W'(1);
			end else begin
				del_col = '0;
				del_row = '0;
			end
		end else begin
			del_col = cur_col_q - COL_W'(1);
			del_row = cur_row_q;
		end
	end

	// Cell addressed by the incoming command, mapped through the row rotation.
	always_comb begin
		case (req.command)
			CMD_PUT: begin
				lcol = cur_col_q;
				lrow = cur_row_q;
			end
			CMD_DELETE: begin
				lcol = del_col;
				lrow = del_row;
			end
			default: begin
				lcol = req_col;
				lrow = req_row;
			end
		endcase
		psum = (ROW_W + 1)'(lrow) + (ROW_W + 1)'(top_q);
		if (psum >= (ROW_W + 1)'(ROWS)) begin
			phys_row = ROW_W'(psum - (ROW_W + 1)'(ROWS));
		end else begin
			phys_row = ROW_W'(psum);
		end
	end

	// Latch the accepted beat and its cell address.
	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			cmd_s1  <= req.command;
			code_s1 <= req.char_code;
			col_s1  <= lcol;
			row_s1  <= lrow;
			addr_s1 <= lin(phys_row, lcol);
		end
	end

	// Cursor after the latched command.
	always_comb begin
		wrap    = (cmd_s1 == CMD_PUT) &&
			((code_s1 == NEWLINE_CODE) || (cur_col_q == COL_LAST));
		scroll  = wrap && (cur_row_q == ROW_LAST);
		nxt_col = cur_col_q;
		nxt_row = cur_row_q;
		case (cmd_s1)
			CMD_PUT: begin
				if (wrap) begin
					nxt_col = '0;
					nxt_row = scroll ? cur_row_q : cur_row_q + ROW_W'(1);
				end else begin
					nxt_col = cur_col_q + COL_W'(1);
				end
			end
			CMD_DELETE, CMD_PLACE: begin
				nxt_col = col_s1;
				nxt_row = row_s1;
			end
			default: begin
				nxt_col = cur_col_q;
				nxt_row = cur_row_q;
			end
		endcase
		nxt_loc  = lin(nxt_row, nxt_col);
		top_base = lin(top_q, '0);
	end

	// Cursor, row rotation and clearing sweep registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q  <= '0;
			cur_row_q  <= '0;
			top_q      <= '0;
			clr_addr_q <= '0;
			clr_end_q  <= ADDR_LAST;
		end else begin
			if (ctrl.commit) begin
				cur_col_q <= nxt_col;
				cur_row_q <= nxt_row;
				if (scroll) begin
					top_q      <= (top_q == ROW_LAST) ? '0 : top_q + ROW_W'(1);
					clr_addr_q <= top_base;
					clr_end_q  <= top_base + ROW_SPAN;
				end
			end else if (ctrl.clr_we && !status.clr_done) begin
				clr_addr_q <= clr_addr_q + ADDR_W'(1);
			end
		end
	end

	// Memory write port: the clearing sweep, or a committed delete or non-newline put.
	always_comb begin
		mem_we    = ctrl.clr_we || (ctrl.commit &&
			(((cmd_s1 == CMD_PUT) && (code_s1 != NEWLINE_CODE)) ||
			(cmd_s1 == CMD_DELETE)));
		mem_waddr = ctrl.clr_we ? clr_addr_q : addr_s1;
		mem_wdata = (ctrl.clr_we || (cmd_s1 == CMD_DELETE)) ? BLANK_CODE : code_s1;
	end

	always_ff @(posedge clk) begin
		if (mem_we) cells[mem_waddr] <= mem_wdata;
		if (ctrl.rd_en) rdata_q <= cells[addr_s1];
	end

	// Response register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctrl.commit || ctrl.load_rd) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Response register payload.
	always_ff @(posedge clk) begin
		if (ctrl.commit || ctrl.load_rd) begin
			rsp_q.cursor_column   <= 7'(nxt_col);
			rsp_q.cursor_row      <= 5'(nxt_row);
			rsp_q.cursor_location <= 11'(nxt_loc);
			rsp_q.read_char       <= ctrl.load_rd ? rdata_q : 8'h00;
			rsp_q.scrolled        <= ctrl.commit && scroll;
		end
	end

	assign rsp_valid       = rsp_valid_q;
	assign rsp             = rsp_q;
	assign status.is_read  = (cmd_s1 == CMD_READ);
	assign status.scroll   = scroll;
	assign status.out_free = !rsp_valid_q || !rsp_stall;
	assign status.clr_done = (clr_addr_q == clr_end_q);

endmodule

@@ rtl/text_console_writer_top.sv @@
// Top level of the text console writer.
//
// A teletype console of COLUMNS by ROWS character cells with a cursor.
// Requests arrive on the req channel (valid/stall) and each one yields
// exactly one response beat on the rsp channel. A beat moves when valid is
// high and stall is low.
// Put, delete and place-cursor load the response register from the EXEC
// state once the output register is free; read-cell loads it from the READ
// state, as the screen memory read is registered. The next request is taken
// only back in the IDLE state, so only one request is in flight.
// A put or newline that runs past the last row scrolls: the screen rows
// rotate through a row pointer, and the row that becomes the bottom is
// blanked one cell per cycle, while the request channel stalls until the
// whole row is blank.
// After reset the whole screen is written with spaces, one cell per cycle;
// the request channel stalls until the whole screen is blank.
// When the receiver stalls, the response holds and the block waits with its
// next response until the current one is taken.
module text_console_writer_top import tcw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	ctrl_t   ctrl;
	status_t status;

	tcw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.status    (status),
		.ctrl      (ctrl)
	);

	tcw_dpath #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.ctrl      (ctrl),
		.status    (status),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

@@ rtl/tcw_checker.sv @@
// Port-level checks for the text console writer, bound to its top level.
module tcw_checker import tcw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	// A stalled response beat stays valid and unchanged.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// Only one request is in flight: the cycle after a beat is taken stalls.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted back to back");

	// The linear location agrees with the reported row and column.
	a_location: assert property (@(posedge clk) disable iff (!arst_n)
		(ROWS <= 32) && rsp_valid |->
		rsp.cursor_location ==
		11'(int'(rsp.cursor_row) * COLUMNS + int'(rsp.cursor_column)))
		else $error("cursor location does not match cursor");

	// A scroll leaves the cursor at the start of the last row.
	a_scroll_pos: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.scrolled |->
		(rsp.cursor_row == 5'(ROWS - 1)) && (rsp.cursor_column == 7'd0))
		else $error("scroll with cursor off the last row start");

endmodule

bind text_console_writer_top tcw_checker #(
	.COLUMNS (COLUMNS),
	.ROWS    (ROWS)
) u_tcw_checker (.*);

@@ dv/text_console_writer_top_test.sv @@
// Self-checking testbench for the text console writer: shadow screen predictor and stimulus.
module text_console_writer_top_test;
	import tcw_pkg::*;

	localparam int SCREEN_COLS  = 80;
	localparam int SCREEN_ROWS  = 25;
	localparam int CELL_TOTAL   = SCREEN_COLS * SCREEN_ROWS;
	localparam int LONG_HOLD    = 400;
	localparam int IDLE_LIMIT   = 20000;
	localparam int DRAIN_CYCLES = 200;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	// Shadow copy of the console: screen contents and cursor.
	logic [7:0] shadow_screen [0:CELL_TOTAL-1];
	int cur_col;
	int cur_row;

	// Responses predicted for accepted requests, oldest first.
	rsp_t awaited_rsps [$];

	int fail_count      = 0;
	int items_sent      = 0;
	int results_checked = 0;
	int scrolls_seen    = 0;
	int reads_done      = 0;
	int idle_cycles     = 0;
	bit no_gaps         = 1'b0;
	bit hold_request    = 1'b0;

	text_console_writer_top #(
		.COLUMNS(SCREEN_COLS),
		.ROWS   (SCREEN_ROWS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always #4 clk = ~clk;

	// Idle length: mostly none or short, now and then long.
	function automatic int pick_gap();
		int roll;
		if (no_gaps) begin
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 60) begin
			return 0;
		end else if (roll < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// Moves the shadow cursor down a row; on the last row the screen scrolls up.
	function automatic bit next_line();
		int i;
		if (cur_row + 1 >= SCREEN_ROWS) begin
			for (i = 0; i < CELL_TOTAL - SCREEN_COLS; i++) begin
				shadow_screen[i] = shadow_screen[i + SCREEN_COLS];
			end
			for (i = CELL_TOTAL - SCREEN_COLS; i < CELL_TOTAL; i++) begin
				shadow_screen[i] = BLANK_CODE;
			end
			cur_row = SCREEN_ROWS - 1;
			return 1'b1;
		end
		cur_row++;
		return 1'b0;
	endfunction

	// Applies one command to the shadow console and returns the response it yields.
	function automatic rsp_t apply_command(input req_t item);
		rsp_t result;
		int   sat_col;
		int   sat_row;
		bit   did_scroll;
		result     = '0;
		did_scroll = 1'b0;
		sat_col    = (item.column >= SCREEN_COLS) ? SCREEN_COLS - 1 : int'(item.column);
		sat_row    = (item.row >= SCREEN_ROWS) ? SCREEN_ROWS - 1 : int'(item.row);
		case (item.command)
			CMD_PUT: begin
				if (item.char_code == NEWLINE_CODE) begin
					cur_col    = 0;
					did_scroll = next_line();
				end else begin
					shadow_screen[cur_row * SCREEN_COLS + cur_col] = item.char_code;
					cur_col++;
					if (cur_col >= SCREEN_COLS) begin
						cur_col    = 0;
						did_scroll = next_line();
					end
				end
			end
			CMD_DELETE: begin
				// At column zero step to the end of the row above, except at home.
				if (cur_col == 0) begin
					if (cur_row != 0) begin
						cur_col = SCREEN_COLS - 1;
						cur_row--;
					end
				end else begin
					cur_col--;
				end
				shadow_screen[cur_row * SCREEN_COLS + cur_col] = BLANK_CODE;
			end
			CMD_READ: begin
				result.read_char = shadow_screen[sat_row * SCREEN_COLS + sat_col];
				reads_done++;
			end
			default: begin
				cur_col = sat_col;
				cur_row = sat_row;
			end
		endcase
		result.cursor_column   = 7'(cur_col);
		result.cursor_row      = 5'(cur_row);
		result.cursor_location = 11'(cur_row * SCREEN_COLS + cur_col);
		result.scrolled        = did_scroll;
		if (did_scroll) begin
			scrolls_seen++;
		end
		return result;
	endfunction

	function automatic req_t make_req(input cmd_t cmd, input int code, input int col,
			input int row);
		req_t item;
		item.command   = cmd;
		item.char_code = 8'(code);
		item.column    = 7'(col);
		item.row       = 5'(row);
		return item;
	endfunction

	// Random request; fields mostly in range, sometimes anywhere in their width.
	function automatic req_t random_item();
		req_t item;
		int   pick;
		item.char_code = 8'($urandom_range(0, 255));
		item.column    = 7'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
			: $urandom_range(0, SCREEN_COLS - 1));
		item.row       = 5'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
			: $urandom_range(0, SCREEN_ROWS - 1));
		pick = $urandom_range(0, 99);
		if (pick < 58) begin
			item.command = CMD_PUT;
			if ($urandom_range(0, 9) == 0) begin
				item.char_code = NEWLINE_CODE;
			end else if ($urandom_range(0, 3) != 0) begin
				item.char_code = 8'($urandom_range(32, 126));
			end
		end else if (pick < 70) begin
			item.command = CMD_DELETE;
		end else if (pick < 85) begin
			item.command = CMD_READ;
			// Half the reads look at the cursor row or the one above, where text was written.
			if ($urandom_range(0, 1) == 0) begin
				item.row = 5'((cur_row > 0) ? cur_row - $urandom_range(0, 1) : 0);
			end
		end else begin
			item.command = CMD_PLACE;
		end
		return item;
	endfunction

	// Offers one request beat, records its prediction on acceptance, then may idle.
	task automatic send_beat(input req_t item);
		int gap;
		@(negedge clk);
		req       <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		awaited_rsps.push_back(apply_command(item));
		items_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			req_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Field extremes, every command and each corner of cursor movement.
	task automatic test_directed();
		send_beat(make_req(CMD_PUT, 8'h48, 127, 31));
		send_beat(make_req(CMD_PUT, 8'hFF, 0, 0));
		send_beat(make_req(CMD_PUT, 8'h00, 0, 0));
		send_beat(make_req(CMD_READ, 8'hFF, 0, 0));
		send_beat(make_req(CMD_READ, 0, 1, 0));
		send_beat(make_req(CMD_PUT, NEWLINE_CODE, 0, 0));
		send_beat(make_req(CMD_PUT, 8'h61, 0, 0));
		send_beat(make_req(CMD_DELETE, 0, 0, 0));
		// Delete at the start of a line goes to the last column of the row above.
		send_beat(make_req(CMD_DELETE, 8'hFF, 127, 31));
		send_beat(make_req(CMD_PLACE, 0, 0, 0));
		// Delete at home stays at home and blanks the cell.
		send_beat(make_req(CMD_DELETE, 0, 0, 0));
		send_beat(make_req(CMD_READ, 0, 127, 31));
		send_beat(make_req(CMD_PLACE, 0, 127, 31));
		// Writing the bottom right cell wraps and scrolls.
		send_beat(make_req(CMD_PUT, 8'h5A, 0, 0));
		send_beat(make_req(CMD_READ, 0, SCREEN_COLS - 1, SCREEN_ROWS - 2));
		send_beat(make_req(CMD_READ, 0, 0, 0));
		send_beat(make_req(CMD_PUT, NEWLINE_CODE, 0, 0));
		send_beat(make_req(CMD_PLACE, 0, SCREEN_COLS - 1, 3));
		send_beat(make_req(CMD_PUT, 8'h71, 0, 0));
		send_beat(make_req(CMD_PLACE, 0, 100, 7));
		send_beat(make_req(CMD_PLACE, 0, 12, 30));
		send_beat(make_req(CMD_READ, 0, SCREEN_COLS - 1, SCREEN_ROWS - 3));
		send_beat(make_req(CMD_PUT, 8'h7F, 0, 0));
	endtask

	// Mixed random traffic of all commands.
	task automatic test_text_stream(input int count);
		repeat (count) send_beat(random_item());
	endtask

	// Text typed near the bottom of the screen so that it scrolls often.
	task automatic test_scroll_churn(input int count);
		req_t item;
		int   i;
		int   pick;
		for (i = 0; i < count; i++) begin
			item = random_item();
			pick = $urandom_range(0, 99);
			if (i % 40 == 0) begin
				item.command = CMD_PLACE;
				item.row     = 5'($urandom_range(SCREEN_ROWS - 2, SCREEN_ROWS - 1));
				item.column  = 7'($urandom_range(0, SCREEN_COLS - 1));
			end else if (pick < 75) begin
				item.command   = CMD_PUT;
				item.char_code = ($urandom_range(0, 9) == 0) ? NEWLINE_CODE
					: 8'($urandom_range(32, 126));
			end else if (pick < 90) begin
				item.command = CMD_READ;
				item.row     = 5'($urandom_range(SCREEN_ROWS - 5, SCREEN_ROWS - 1));
				item.column  = 7'($urandom_range(0, SCREEN_COLS - 1));
			end else begin
				item.command = CMD_DELETE;
			end
			send_beat(item);
		end
	endtask

	// The receiver holds off for a long stretch while requests keep coming.
	task automatic test_backpressure(input int count);
		no_gaps      = 1'b1;
		hold_request = 1'b1;
		repeat (count) send_beat(random_item());
		no_gaps = 1'b0;
	endtask

	// Back-to-back beats with no idling on either side.
	task automatic test_burst(input int count);
		no_gaps = 1'b1;
		repeat (count) send_beat(random_item());
		no_gaps = 1'b0;
	endtask

	function automatic void compare_field(input string what, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
			fail_count++;
		end
	endfunction

	// Check each response beat against the oldest prediction.
	always @(posedge clk) begin : check_rsp
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (awaited_rsps.size() == 0) begin
				$display("%0t: response beat with no request outstanding: %h", $time, rsp);
				fail_count++;
			end else begin
				want = awaited_rsps.pop_front();
				results_checked++;
				compare_field("cursor_column", want.cursor_column, rsp.cursor_column);
				compare_field("cursor_row", want.cursor_row, rsp.cursor_row);
				compare_field("cursor_location", want.cursor_location, rsp.cursor_location);
				compare_field("read_char", want.read_char, rsp.read_char);
				compare_field("scrolled", want.scrolled, rsp.scrolled);
			end
		end
	end

	// Receiver: random stalls, plus one long hold when the test asks for it.
	initial begin : receiver
		int stall_left;
		int n;
		rsp_stall  = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				stall_left   = LONG_HOLD;
			end
			if (stall_left > 0) begin
				rsp_stall <= 1'b1;
				stall_left--;
			end else begin
				n = pick_gap();
				if (n > 0) begin
					rsp_stall  <= 1'b1;
					stall_left = n - 1;
				end else begin
					rsp_stall <= 1'b0;
				end
			end
		end
	end

	// Watchdog: too many cycles without any beat moving ends the run.
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
			$display("text_console_writer_top_test: FAIL");
			$finish;
		end
	end

	// Main sequence.
	initial begin
		int i;
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		for (i = 0; i < CELL_TOTAL; i++) begin
			shadow_screen[i] = BLANK_CODE;
		end
		cur_col = 0;
		cur_row = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_text_stream(650);
		test_scroll_churn(300);
		test_backpressure(40);
		test_burst(150);

		@(negedge clk);
		req_valid <= 1'b0;
		while (awaited_rsps.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		fail_count += awaited_rsps.size();

		$display("Sent %0d requests and checked %0d responses, with %0d scrolls and %0d reads.",
			items_sent, results_checked, scrolls_seen, reads_done);
		$display("Ran edge cases, random text, bottom-row scrolling, a long hold and bursts.");
		if (fail_count == 0) begin
			$display("text_console_writer_top_test: PASS");
		end else begin
			$display("text_console_writer_top_test: FAIL");
		end
		$finish;
	end

endmodule

@@ text_console_writer_top.f @@
rtl/tcw_pkg.sv
rtl/tcw_ctrl.sv
rtl/tcw_dpath.sv
rtl/text_console_writer_top.sv
rtl/tcw_checker.sv
dv/text_console_writer_top_test.sv
